>>> rtl/core/gwal_pkg.sv
// shared types and constants of the gated window average level unit
// field widths, register indexes, reset values and divider request/response
// no dependencies
`default_nettype none

package gwal_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int TANK_W      = 10;
  localparam int LEVEL_W     = 12;
  localparam int PCT_W       = 20;
  localparam int LIT_W       = 30;
  localparam int DIST_W      = 32;
  localparam int CNT_W       = 5;

  // divider: 19-bit dividend covers window sum and scaled percent numerator
  localparam int DIV_W       = 19;
  localparam int DVS_W       = 12;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 2;

  localparam int PCT_SCALE   = 100;

  localparam logic [LEVEL_W-1:0] EMPTY_RST = 12'd61;
  localparam logic [LEVEL_W-1:0] FULL_RST  = 12'd233;
  localparam logic [TANK_W-1:0]  TANK_RST  = 10'd40;
  localparam logic [LEVEL_W-1:0] RANGE_RST = 12'd260;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMPTY = 2'd0,
    REG_FULL  = 2'd1,
    REG_TANK  = 2'd2,
    REG_RANGE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/gwal_store.sv
// sample window memory, one write port and one registered read port
// depends on gwal_pkg for the sample width
`default_nettype none

module gwal_store
  import gwal_pkg::*;
#(
  parameter int  DEPTH  = 30,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic [SAMPLE_W-1:0] wr_data,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output      logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gwal_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on gwal_pkg for div_req_t and div_rsp_t
`default_nettype none

module gwal_div
  import gwal_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  localparam int ITER_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [ITER_W-1:0] iter_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    shift_val;
  logic              q_bit;
  logic [DVS_W:0]    diff_val;

  always_comb begin
    shift_val = {rem_r, dvd_r[DIV_W-1]};
    q_bit     = (shift_val >= {1'b0, dvs_r});
    diff_val  = shift_val - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(DIV_W);
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // quotient bits shift in behind the dividend bits
        rem_r  <= q_bit ? diff_val[DVS_W-1:0] : shift_val[DVS_W-1:0];
        dvd_r  <= {dvd_r[DIV_W-2:0], q_bit};
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

`default_nettype wire

>>> rtl/core/gated_window_average_level_unit.sv
// top level of the gated window average level unit: sequencer, window state,
// tolerance gate and level mapping; depends on gwal_pkg, gwal_store, gwal_div
`default_nettype none

// channel   direction  handshake          payload
// in_       slave      in_tvalid/tready   in_tdata: sample
// out_      master     out_tvalid/tready  out_tdata: levels, count; out_tuser: flags
// cfg_      slave      cfg_valid/ready    cfg_index, cfg_data
//
// one request at a time: a new request is taken only after the previous result is loaded;
// each request passes a memory read, the multiply states S_MUL and S_SCALE, the update,
// two passes of the one-bit-per-cycle divider (mean, then percent) and the multiply state S_PROD
// reset (rst_n low, synchronous) empties the window and loads the default levels
// a held result only stalls the final output load; a new request is taken meanwhile
// configuration writes are accepted in every cycle

module gated_window_average_level_unit
  import gwal_pkg::*;
#(
  parameter int WINDOW_DEPTH      = 30,
  parameter int TOLERANCE_DIVISOR = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // sample request
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] sample
  // result
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] mean_level, [31:12] percent,
                                                  // [61:32] liters_hundredths,
                                                  // [93:62] distance_hundredths,
                                                  // [98:94] window_count
  output      logic [OUT_TUSER_W-1:0] out_tuser,  // [0] accepted, [1] range_error
  // register writes
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_W + FILL_W;
  localparam int TOL_W  = $clog2(TOLERANCE_DIVISOR + 2);
  localparam int CMP_W  = SUM_W + TOL_W;

  localparam logic [TOL_W-1:0]  TOL_MID  = TOL_W'(TOLERANCE_DIVISOR);
  localparam logic [TOL_W-1:0]  TOL_HI   = TOL_W'(TOLERANCE_DIVISOR + 1);
  localparam logic [TOL_W-1:0]  TOL_LO   = TOL_W'(TOLERANCE_DIVISOR - 1);
  localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(WINDOW_DEPTH);
  localparam logic [PTR_W:0]    DEPTH_P  = (PTR_W + 1)'(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_P   = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic signed [PCT_W-1:0] PCT_MUL = PCT_W'(PCT_SCALE);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MUL    = 11'b000_0000_0010,
    S_SCALE  = 11'b000_0000_0100,
    S_UPD    = 11'b000_0000_1000,
    S_MSTART = 11'b000_0001_0000,
    S_MWAIT  = 11'b000_0010_0000,
    S_PSETUP = 11'b000_0100_0000,
    S_PSTART = 11'b000_1000_0000,
    S_PWAIT  = 11'b001_0000_0000,
    S_PROD   = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [LEVEL_W-1:0] empty_r, full_r, range_r;
  logic [TANK_W-1:0]  tank_r;

  // window state
  logic [FILL_W-1:0]  fill_r;
  logic [SUM_W-1:0]   sum_r;
  logic [PTR_W-1:0]   oldest_r;

  // per-request working registers
  logic [SAMPLE_W-1:0] sample_r, old_r;
  logic [SUM_W-1:0]    ns_r;
  logic [CMP_W-1:0]    lhs_r, hi_r, lo_r;
  logic                accepted_r;
  logic [LEVEL_W-1:0]  mean_r;
  logic [DIV_W-1:0]    num_mag_r;
  logic [DVS_W-1:0]    den_mag_r;
  logic                neg_r, rerr_r;
  logic [PCT_W-1:0]    pct_r;
  logic [LIT_W-1:0]    lit_r;
  logic [DIST_W-1:0]   dist_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  logic in_fire, out_fire;

  // store port
  logic                mem_wr_en;
  logic [PTR_W-1:0]    mem_wr_addr;
  logic [SAMPLE_W-1:0] mem_rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // gate and update terms
  logic              take;
  logic              win_full;
  logic [PTR_W:0]    slot_sum;
  logic [PTR_W:0]    slot_wrap;
  logic [SUM_W-1:0]  sum_add;
  logic [SUM_W-1:0]  sum_swap;

  // percent setup terms
  logic signed [LEVEL_W:0]  diff_s, den_s;
  logic signed [PCT_W-1:0]  diff_ext, num_s, num_abs;
  logic signed [LEVEL_W:0]  den_abs;
  logic [PCT_W-1:0]         pct_pos;

  // scaled outputs
  logic signed [LIT_W:0]  lit_full;
  logic signed [DIST_W:0] dist_full;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // tolerance gate, first sample into an empty window always passes
  always_comb begin
    take      = (fill_r == '0) || ((lhs_r <= hi_r) && (lhs_r > lo_r));
    win_full  = (fill_r == DEPTH_F);
    slot_sum  = {1'b0, oldest_r} + (PTR_W + 1)'(fill_r);
    slot_wrap = (slot_sum >= DEPTH_P) ? (slot_sum - DEPTH_P) : slot_sum;
    sum_add   = sum_r + SUM_W'(sample_r);
    sum_swap  = sum_r - SUM_W'(old_r) + SUM_W'(sample_r);
  end

  // full window overwrites the oldest slot, otherwise append behind the newest
  assign mem_wr_en   = (state_r == S_UPD) && take;
  assign mem_wr_addr = win_full ? oldest_r : slot_wrap[PTR_W-1:0];

  gwal_store #(
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (sample_r),
    .rd_en   (in_fire),
    .rd_addr (oldest_r),
    .rd_data (mem_rd_data)
  );

  // one shared divider: mean first, then the percent quotient
  always_comb begin
    div_req.start    = (state_r == S_MSTART) || (state_r == S_PSTART);
    div_req.dividend = num_mag_r;
    div_req.divisor  = den_mag_r;
    if (state_r == S_MSTART) begin
      div_req.dividend = DIV_W'(sum_r);
      div_req.divisor  = DVS_W'(fill_r);
    end
  end

  gwal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // signed percent numerator and denominator, split into sign and magnitude, and the liters and distance products
  always_comb begin
    diff_s   = $signed({1'b0, mean_r}) - $signed({1'b0, empty_r});
    diff_ext = PCT_W'(diff_s);
    num_s    = diff_ext * PCT_MUL;
    num_abs  = num_s[PCT_W-1] ? -num_s : num_s;
    den_s    = $signed({1'b0, full_r}) - $signed({1'b0, empty_r});
    den_abs  = den_s[LEVEL_W] ? -den_s : den_s;
    pct_pos  = PCT_W'(div_rsp.quotient);
    lit_full  = (LIT_W + 1)'($signed(pct_r)) * (LIT_W + 1)'($signed({1'b0, tank_r}));
    dist_full = (DIST_W + 1)'($signed(pct_r)) * (DIST_W + 1)'($signed({1'b0, range_r}));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_UPD;
      S_UPD:    state_nxt = S_MSTART;
      S_MSTART: state_nxt = S_MWAIT;
      S_MWAIT:  if (div_rsp.done) state_nxt = S_PSETUP;
      S_PSETUP: state_nxt = S_PSTART;
      S_PSTART: state_nxt = S_PWAIT;
      S_PWAIT:  if (div_rsp.done) state_nxt = S_PROD;
      S_PROD:   state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
      empty_r     <= EMPTY_RST;
      full_r      <= FULL_RST;
      tank_r      <= TANK_RST;
      range_r     <= RANGE_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_EMPTY: empty_r <= cfg_data;
          REG_FULL:  full_r  <= cfg_data;
          REG_TANK:  tank_r  <= cfg_data[TANK_W-1:0];
          REG_RANGE: range_r <= cfg_data;
          default:   ;
        endcase
      end

      // window update: append while filling, replace oldest once full
      if ((state_r == S_UPD) && take) begin
        if (win_full) begin
          sum_r    <= sum_swap;
          oldest_r <= (oldest_r == LAST_P) ? '0 : (oldest_r + 1'b1);
        end else begin
          sum_r  <= sum_add;
          fill_r <= fill_r + 1'b1;
        end
      end

      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
    end
    case (state_r)
      S_MUL: begin
        old_r <= mem_rd_data;
        ns_r  <= SUM_W'(fill_r) * SUM_W'(sample_r);
      end
      S_SCALE: begin
        lhs_r <= CMP_W'(ns_r) * CMP_W'(TOL_MID);
        hi_r  <= CMP_W'(sum_r) * CMP_W'(TOL_HI);
        lo_r  <= CMP_W'(sum_r) * CMP_W'(TOL_LO);
      end
      S_UPD: begin
        accepted_r <= take;
      end
      S_MWAIT: begin
        if (div_rsp.done) begin
          mean_r <= div_rsp.quotient[LEVEL_W-1:0];
        end
      end
      S_PSETUP: begin
        num_mag_r <= num_abs[DIV_W-1:0];
        den_mag_r <= den_abs[DVS_W-1:0];
        neg_r     <= num_s[PCT_W-1] ^ den_s[LEVEL_W];
        rerr_r    <= (full_r == empty_r);
      end
      S_PWAIT: begin
        // truncation toward zero: divide magnitudes, then restore the sign
        if (div_rsp.done) begin
          if (rerr_r) begin
            pct_r <= '0;
          end else if (neg_r) begin
            pct_r <= -pct_pos;
          end else begin
            pct_r <= pct_pos;
          end
        end
      end
      S_PROD: begin
        lit_r  <= lit_full[LIT_W-1:0];
        dist_r <= dist_full[DIST_W-1:0];
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_tdata_r <= {(OUT_TDATA_W - LEVEL_W - PCT_W - LIT_W - DIST_W - CNT_W)'(0),
                          CNT_W'(fill_r), dist_r, lit_r, pct_r, mean_r};
          out_tuser_r <= {rerr_r, accepted_r};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/gwal_checker.sv
// port-level checks of the gated window average level unit, bound to the top
// depends on gwal_pkg for port widths
`default_nettype none

module gwal_checker
  import gwal_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

  // equal levels force all mapped outputs to zero
  a_rerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata[93:12] == '0))
    else $error("mapped outputs nonzero with range error");

endmodule

bind gated_window_average_level_unit gwal_checker u_gwal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> tb/tb_gated_window_average_level_unit.sv
// self-checking testbench for gated_window_average_level_unit
// scoreboard class tracks the sample window and level mapping; tasks drive the streams
// depends on gwal_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb_gated_window_average_level_unit;
  import gwal_pkg::*;

  localparam int DEPTH     = 30;
  localparam int TOL       = 10;
  localparam int SETTLE    = 60;   // settle time after the last result, longer than the accept-to-result path
  localparam int PER_SET   = 100;  // random requests per register setting
  localparam int SETS      = 4;    // register settings per idle profile

  // one expected result: the data fields and the accepted and range error flags
  typedef struct {
    logic [LEVEL_W-1:0] mean;
    logic [PCT_W-1:0]   pct;
    logic [LIT_W-1:0]   lit;
    logic [DIST_W-1:0]  distance;
    logic               acc;
    logic [CNT_W-1:0]   cnt;
    logic               rerr;
  } level_result_t;

  // mirror of the window and the mapping registers, plus the queue of pending results
  class level_scoreboard;
    logic [SAMPLE_W-1:0] win [DEPTH];
    int unsigned         head, fill, sum;
    logic [LEVEL_W-1:0]  empty_lv, full_lv, range_cap;
    logic [TANK_W-1:0]   tank_cap;
    level_result_t       expected_levels [$];
    int                  errors;

    function new();
      head      = 0;
      fill      = 0;
      sum       = 0;
      empty_lv  = EMPTY_RST;
      full_lv   = FULL_RST;
      tank_cap  = TANK_RST;
      range_cap = RANGE_RST;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_EMPTY: empty_lv  = d[LEVEL_W-1:0];
        REG_FULL:  full_lv   = d[LEVEL_W-1:0];
        REG_TANK:  tank_cap  = d[TANK_W-1:0];
        REG_RANGE: range_cap = d[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // smallest and largest sample the gate lets through right now
    function void accept_bounds(output int lo, output int hi);
      if (fill == 0) begin
        lo = 0;
        hi = 4095;
      end else begin
        lo = int'((longint'(TOL - 1) * sum) / (longint'(TOL) * fill)) + 1;
        hi = int'((longint'(TOL + 1) * sum) / (longint'(TOL) * fill));
      end
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      longint        lhs, num, den, pct, lit, distance;
      bit            take;
      int unsigned   slot, mean;
      level_result_t r;
      if (fill == 0) begin
        take = 1;
      end else begin
        lhs  = longint'(TOL) * fill * s;
        take = (lhs <= longint'(TOL + 1) * sum) && (lhs > longint'(TOL - 1) * sum);
      end
      if (take) begin
        if (fill < DEPTH) begin
          slot = (head + fill) % DEPTH;
          win[slot] = s;
          fill++;
          sum += s;
        end else begin
          // full window: the new sample takes the slot of the oldest one
          sum = sum - win[head] + s;
          win[head] = s;
          head = (head + 1) % DEPTH;
        end
      end
      mean     = sum / fill;
      pct      = 0;
      lit      = 0;
      distance = 0;
      if (full_lv != empty_lv) begin
        num      = (longint'(mean) - longint'(empty_lv)) * PCT_SCALE;
        den      = longint'(full_lv) - longint'(empty_lv);
        pct      = num / den;  // signed division truncates toward zero
        lit      = pct * longint'(tank_cap);
        distance = pct * longint'(range_cap);
      end
      r.mean     = mean[LEVEL_W-1:0];
      r.pct      = pct[PCT_W-1:0];
      r.lit      = lit[LIT_W-1:0];
      r.distance = distance[DIST_W-1:0];
      r.acc      = take;
      r.cnt      = fill[CNT_W-1:0];
      r.rerr     = (full_lv == empty_lv);
      expected_levels.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t %s expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td, logic [OUT_TUSER_W-1:0] tu);
      level_result_t r;
      if (expected_levels.size() == 0) begin
        $display("%0t unexpected result expected none actual %h/%h", $time, td, tu);
        errors++;
        return;
      end
      r = expected_levels.pop_front();
      cmp("mean_level",          32'(r.mean), 32'(td[11:0]));
      cmp("percent",             32'(r.pct),  32'(td[31:12]));
      cmp("liters_hundredths",   32'(r.lit),  32'(td[61:32]));
      cmp("distance_hundredths", r.distance,  td[93:62]);
      cmp("window_count",        32'(r.cnt),  32'(td[98:94]));
      cmp("accepted",            32'(r.acc),  32'(tu[0]));
      cmp("range_error",         32'(r.rerr), 32'(tu[1]));
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [11:0] sample, upper bits zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [11:0] mean, [31:12] percent, [61:32] liters,
                                             // [93:62] distance, [98:94] window count
  logic [OUT_TUSER_W-1:0] out_tuser;         // [0] accepted, [1] range error
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // idle rates in percent, changed per phase by the stimulus process
  int send_idle = 0;
  int recv_idle = 0;

  level_scoreboard sb = new();

  gated_window_average_level_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle);
  end

  // all handshakes are seen here at the rising edge; results are checked before
  // a new request is noted, though a result can never belong to a same-edge request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata[SAMPLE_W-1:0]);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  // entered and left at a falling edge; valid stays up afterwards so that
  // back-to-back requests need no gap
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_TDATA_W-SAMPLE_W){1'b0}}, s};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg_req(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // sender holds off until every pending result is out, then lets the unit settle
  task automatic drain_window();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // tank data carries random upper bits so the 10-bit truncation is exercised
  task automatic set_levels(logic [11:0] e, logic [11:0] f, logic [11:0] t, logic [11:0] r);
    drain_window();
    write_reg_req(REG_EMPTY, e);
    write_reg_req(REG_FULL,  f);
    write_reg_req(REG_TANK,  t);
    write_reg_req(REG_RANGE, r);
  endtask

  // mostly samples the gate lets in, some right on or just past its edges, some noise
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int lo, hi, r, v;
    sb.accept_bounds(lo, hi);
    r = $urandom_range(99);
    if (r < 20 || lo > hi) begin
      v = $urandom_range(4095);
    end else if (r < 32) begin
      case ($urandom_range(3))
        0: v = lo;
        1: v = hi;
        2: v = lo - 1;
        default: v = hi + 1;
      endcase
    end else begin
      if (hi > 4095) hi = 4095;
      if (lo > hi) lo = hi;
      v = $urandom_range(hi, lo);
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // one random register setting: now and then equal levels or the full-scale pair in either order
  task automatic random_levels();
    logic [11:0] e, f;
    e = 12'($urandom_range(4095));
    f = 12'($urandom_range(4095));
    case ($urandom_range(5))
      0: f = e;
      1: begin
        e = 12'd0;
        f = 12'd4095;
      end
      2: begin
        e = 12'd4095;
        f = 12'd0;
      end
      default: ;
    endcase
    set_levels(e, f, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
  endtask

  initial begin
    int lo, hi;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: first sample into an empty window goes in untested,
    // then both sample extremes are thrown at the gate and rejected
    send_sample(12'd2000);
    send_sample(12'd0);
    send_sample(12'd4095);
    // gate edges: last sample taken on each side and the first one refused
    sb.accept_bounds(lo, hi);
    send_sample(hi[11:0]);
    sb.accept_bounds(lo, hi);
    send_sample(12'(hi + 1));
    sb.accept_bounds(lo, hi);
    send_sample(lo[11:0]);
    sb.accept_bounds(lo, hi);
    send_sample(12'(lo - 1));

    // steepest positive mapping and largest capacities
    set_levels(12'd0, 12'd1, 12'hfff, 12'hfff);
    send_sample(pick_sample());
    send_sample(pick_sample());
    // full below empty: negative divisor, truncation toward zero
    set_levels(12'd1, 12'd0, 12'h3ff, 12'hfff);
    send_sample(pick_sample());
    send_sample(pick_sample());
    set_levels(12'd4095, 12'd0, 12'h3ff, 12'd4095);
    send_sample(pick_sample());
    // equal levels force zero outputs with the range error flag
    set_levels(12'd2048, 12'd2048, 12'd40, 12'd260);
    send_sample(pick_sample());
    send_sample(pick_sample());
    // zero capacities
    set_levels(12'd61, 12'd233, 12'hc00, 12'd0);
    send_sample(pick_sample());
    send_sample(pick_sample());

    // random part over three idle profiles, register changes only when drained
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 27;
          recv_idle = 58;
        end
        1: begin
          send_idle = 58;
          recv_idle = 27;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int k = 0; k < SETS; k++) begin
        random_levels();
        for (int i = 0; i < PER_SET; i++) send_sample(pick_sample());
      end
    end

    drain_window();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
